### rtl/peer_table_link_quality_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the peer table link quality block
// Shared concurrent assertion forms, clocked on clk_i, idle during reset.
// ----------------------------------------------------------------------------
`ifndef PEER_TABLE_LINK_QUALITY_TOP_MACROS_SVH
`define PEER_TABLE_LINK_QUALITY_TOP_MACROS_SVH

// same-cycle implication
`define PTLQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTLQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ptlq_pkg.sv
// ----------------------------------------------------------------------------
// Peer table link quality package
// Sizes, codes, request/response types and shared helpers.
// ----------------------------------------------------------------------------
package ptlq_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // queue depth must be a power of two, pointers wrap naturally
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_NUM_W = 42;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] FRESH_RESET   = 32'd60000;
  localparam logic [31:0] WINDOW_RESET  = 32'd10000;
  localparam logic [9:0]  PERMILLE_FULL = 10'd1000;
  localparam logic [15:0] PDR_NONE      = 16'hFFFF;

  // function codes
  localparam logic [1:0] FUNC_HEARTBEAT = 2'd0;
  localparam logic [1:0] FUNC_TICK      = 2'd1;
  localparam logic [1:0] FUNC_GAP       = 2'd2;

  // action codes
  localparam logic [1:0] ACT_REJECT   = 2'd0;
  localparam logic [1:0] ACT_EXISTING = 2'd1;
  localparam logic [1:0] ACT_FREE     = 2'd2;
  localparam logic [1:0] ACT_EVICT    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRESH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;

  typedef enum logic [1:0] {
    OP_HEARTBEAT,
    OP_TICK,
    OP_GAP,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [31:0]       now_ms;
    logic [23:0]       peer_id;
    logic [31:0]       seq;
    logic [31:0]       sender_up_ms;
    logic signed [7:0] rssi;
    logic [31:0]       off_ms;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [4:0]        slot;
    logic [1:0]        action;
    logic signed [7:0] rssi_avg;
    logic [31:0]       gaps_total;
    logic [15:0]       window_pdr;
    logic              window_closed;
    logic [9:0]        observed_permille;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_t;

  typedef struct packed {
    op_e  op;
    req_t req;
  } q_item_t;

  typedef struct packed {
    logic [23:0]       id;
    logic [31:0]       last_heard;
    logic signed [7:0] rssi_avg;
    logic [31:0]       last_seq;
    logic [31:0]       rx_cnt;
    logic [31:0]       gap_cnt;
    logic [31:0]       win_rx;
    logic [31:0]       win_gap;
    logic [15:0]       win_pdr;
    logic [31:0]       uptime;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  function automatic entry_t clear_entry(input logic [23:0] id);
    entry_t e;
    e         = '0;
    e.id      = id;
    e.win_pdr = PDR_NONE;
    return e;
  endfunction

endpackage

### rtl/ptlq_if.sv
// ----------------------------------------------------------------------------
// Peer table link quality channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface ptlq_req_if;
  logic            valid;
  logic            ready;
  ptlq_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ptlq_rsp_if;
  logic            valid;
  logic            ready;
  ptlq_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ptlq_cfg_if;
  logic            valid;
  logic            ready;
  ptlq_pkg::cfg_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/ptlq_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptlq_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptlq_pkg::div_req_t  req_i,
  output ptlq_pkg::div_rsp_t  rsp_o
);
  import ptlq_pkg::*;

  logic [DIV_DEN_W:0]   rem_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIV_DEN_W:0] rem_sh;
  logic [DIV_DEN_W:0] den_x;
  logic               ge;

  assign rem_sh = {rem_q[DIV_DEN_W-1:0], quo_q[DIV_NUM_W-1]};
  assign den_x  = {1'b0, den_q};
  assign ge     = rem_sh >= den_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      // one-cycle pulse after the last step
      done_q <= busy_q && !req_i.start && (cnt_q == DIV_CNT_W'(1));
      if (req_i.start) begin
        rem_q  <= '0;
        quo_q  <= req_i.num;
        den_q  <= req_i.den;
        cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? (rem_sh - den_x) : rem_sh;
        quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

### rtl/ptlq_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, classifies the function code, queues them for the engine.
// ----------------------------------------------------------------------------
`include "peer_table_link_quality_top_macros.svh"

module ptlq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ptlq_req_if.sink           req_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output ptlq_pkg::q_item_t  item_o
);
  import ptlq_pkg::*;

  q_item_t             q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q;
  logic [QUEUE_AW-1:0] rd_ptr_q;
  logic [QUEUE_CW-1:0] cnt_q;
  logic                push;
  logic                pop;
  q_item_t             in_item;

  always_comb begin
    in_item.req = req_i.payload;
    unique case (req_i.payload.func)
      FUNC_HEARTBEAT: in_item.op = OP_HEARTBEAT;
      FUNC_TICK:      in_item.op = OP_TICK;
      FUNC_GAP:       in_item.op = OP_GAP;
      default:        in_item.op = OP_NONE;
    endcase
  end

  assign req_i.ready  = cnt_q != QUEUE_CW'(QUEUE_DEPTH);
  assign push         = req_i.valid && req_i.ready;
  assign item_valid_o = cnt_q != '0;
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + QUEUE_CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QUEUE_CW'(1);
      end
    end
  end

  `PTLQ_ASSERT_NEXT(a_queue_fill, push && !pop, cnt_q == $past(cnt_q) + QUEUE_CW'(1), "queue count did not grow on push")

endmodule

### rtl/ptlq_back.sv
// ----------------------------------------------------------------------------
// Table engine
// Peer table scan, allocation, sequence accounting and window closing.
// ----------------------------------------------------------------------------
`include "peer_table_link_quality_top_macros.svh"

module ptlq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  ptlq_cfg_if.sink           cfg_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  ptlq_pkg::q_item_t  item_i,
  output ptlq_pkg::div_req_t div_req_o,
  input  ptlq_pkg::div_rsp_t div_rsp_i,
  ptlq_rsp_if.source         rsp_o
);
  import ptlq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_HB_SCAN, S_HB_PICK, S_HB_ACC, S_HB_UPD, S_HB_WR,
    S_TK_RD, S_TK_MUL, S_TK_START, S_TK_DIV, S_TK_WR,
    S_OBS_MIN, S_OBS_MUL, S_OBS_START, S_OBS_DIV, S_TK_FIN, S_RESP
  } state_e;

  state_e state_q;

  // table memory
  entry_t             mem [TABLE_ENTRIES];
  entry_t             mem_q;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;
  logic [SLOT_W-1:0]  mem_ra;

  logic [31:0]              fresh_q;
  logic [31:0]              window_q;
  logic [TABLE_ENTRIES-1:0] used_q;
  req_t                     cur_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     chk_vld_q;
  logic [SLOT_W-1:0]        chk_idx_q;
  logic                     hit_q;
  logic [SLOT_W-1:0]        hit_slot_q;
  entry_t                   hit_e_q;
  logic                     free_any_q;
  logic [SLOT_W-1:0]        free_slot_q;
  logic                     stale_any_q;
  logic [SLOT_W-1:0]        stale_slot_q;
  logic [31:0]              stale_lh_q;
  logic [SLOT_W-1:0]        weak_slot_q;
  logic signed [7:0]        weak_avg_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [1:0]               act_q;
  entry_t                   work_q;
  logic                     restart_q;
  logic                     adv_q;
  logic [31:0]              gap_q;
  logic [DIV_NUM_W-1:0]     num_q;
  logic [DIV_DEN_W-1:0]     den_q;
  logic                     div_start_q;
  logic [31:0]              wst_q;
  logic [31:0]              unobs_q;
  logic [9:0]               share_q;
  logic                     closed_q;
  logic                     res_acc_q;
  logic                     rsp_valid_q;
  rsp_t                     rsp_q;

  // scan and accounting helpers
  logic [31:0]        age;
  logic               is_stale;
  logic               tick_due;
  logic signed [8:0]  rssi_x9;
  logic signed [8:0]  weak_x9;
  logic               newc_strong;
  logic signed [10:0] avg_x;
  logic signed [10:0] rssi_x11;
  logic signed [10:0] blend_sum;
  logic signed [10:0] blend_adj;
  logic signed [7:0]  blend_avg;
  logic               had;
  logic               rebooted;
  logic               restarted;
  logic [31:0]        obs_min;
  entry_t             tk_clr;

  assign age      = cur_q.now_ms - mem_q.last_heard;
  assign is_stale = age >= fresh_q;
  assign tick_due = (item_i.req.now_ms - wst_q) >= window_q;

  assign rssi_x9     = $signed({cur_q.rssi[7], cur_q.rssi});
  assign weak_x9     = $signed({weak_avg_q[7], weak_avg_q}) + 9'sd6;
  assign newc_strong = rssi_x9 > weak_x9;

  // 7/8 blend, divide truncating toward zero
  assign avg_x     = $signed({{3{work_q.rssi_avg[7]}}, work_q.rssi_avg});
  assign rssi_x11  = $signed({{3{cur_q.rssi[7]}}, cur_q.rssi});
  assign blend_sum = (avg_x <<< 3) - avg_x + rssi_x11;
  assign blend_adj = blend_sum[10] ? (blend_sum + 11'sd7) : blend_sum;
  assign blend_avg = blend_adj[10:3];

  assign had       = work_q.rx_cnt != '0;
  assign rebooted  = had && ((cur_q.sender_up_ms + 32'd1000) < work_q.uptime);
  assign restarted = had && (cur_q.seq < work_q.last_seq) &&
                     ((work_q.last_seq - cur_q.seq) > 32'd100);

  assign obs_min = (unobs_q > window_q) ? window_q : unobs_q;

  // entry read during a tick, window counters restarted
  always_comb begin
    tk_clr         = mem_q;
    tk_clr.win_rx  = '0;
    tk_clr.win_gap = '0;
  end

  assign mem_ra = cnt_q[SLOT_W-1:0];
  assign mem_we = (state_q == S_HB_WR) || (state_q == S_TK_WR);
  assign mem_wa = (state_q == S_HB_WR) ? slot_q : cnt_q[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= work_q;
    end
    mem_q <= mem[mem_ra];
  end

  assign item_ready_o = state_q == S_IDLE;
  assign cfg_i.ready  = 1'b1;

  assign div_req_o.start = div_start_q;
  assign div_req_o.num   = num_q;
  assign div_req_o.den   = den_q;

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fresh_q      <= FRESH_RESET;
      window_q     <= WINDOW_RESET;
      used_q       <= '0;
      cur_q        <= '0;
      cnt_q        <= '0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      hit_q        <= 1'b0;
      hit_slot_q   <= '0;
      hit_e_q      <= '0;
      free_any_q   <= 1'b0;
      free_slot_q  <= '0;
      stale_any_q  <= 1'b0;
      stale_slot_q <= '0;
      stale_lh_q   <= '0;
      weak_slot_q  <= '0;
      weak_avg_q   <= '0;
      slot_q       <= '0;
      act_q        <= ACT_REJECT;
      work_q       <= '0;
      restart_q    <= 1'b0;
      adv_q        <= 1'b0;
      gap_q        <= '0;
      num_q        <= '0;
      den_q        <= '0;
      div_start_q  <= 1'b0;
      wst_q        <= '0;
      unobs_q      <= '0;
      share_q      <= PERMILLE_FULL;
      closed_q     <= 1'b0;
      res_acc_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
    end else begin
      // divider start pulse, in the cycle after the start states
      div_start_q <= ((state_q == S_TK_START) && (den_q != '0)) ||
                     (state_q == S_OBS_START);

      if (cfg_i.valid) begin
        if (cfg_i.payload.index == CFG_FRESH)  fresh_q  <= cfg_i.payload.data;
        if (cfg_i.payload.index == CFG_WINDOW) window_q <= cfg_i.payload.data;
      end

      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            cur_q     <= item_i.req;
            res_acc_q <= 1'b0;
            closed_q  <= 1'b0;
            cnt_q     <= '0;
            unique case (item_i.op)
              OP_HEARTBEAT: begin
                chk_vld_q   <= 1'b0;
                hit_q       <= 1'b0;
                free_any_q  <= 1'b0;
                stale_any_q <= 1'b0;
                state_q     <= S_HB_SCAN;
              end
              OP_TICK: begin
                state_q <= tick_due ? S_TK_RD : S_RESP;
              end
              OP_GAP: begin
                unobs_q <= unobs_q + item_i.req.off_ms;
                state_q <= S_RESP;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end

        // one entry per cycle, read data is registered, so the checked slot is kept in chk_idx_q
        S_HB_SCAN: begin
          chk_vld_q <= cnt_q != CNT_W'(TABLE_ENTRIES);
          chk_idx_q <= cnt_q[SLOT_W-1:0];
          if (cnt_q != CNT_W'(TABLE_ENTRIES)) cnt_q <= cnt_q + CNT_W'(1);
          if (chk_vld_q) begin
            if (used_q[chk_idx_q] && (mem_q.id == cur_q.peer_id) && !hit_q) begin
              hit_q      <= 1'b1;
              hit_slot_q <= chk_idx_q;
              hit_e_q    <= mem_q;
            end
            if (!used_q[chk_idx_q] && !free_any_q) begin
              free_any_q  <= 1'b1;
              free_slot_q <= chk_idx_q;
            end
            if (is_stale && (!stale_any_q || (mem_q.last_heard < stale_lh_q))) begin
              stale_any_q  <= 1'b1;
              stale_slot_q <= chk_idx_q;
              stale_lh_q   <= mem_q.last_heard;
            end
            if ((chk_idx_q == '0) || ($signed(mem_q.rssi_avg) < $signed(weak_avg_q))) begin
              weak_slot_q <= chk_idx_q;
              weak_avg_q  <= mem_q.rssi_avg;
            end
            if (chk_idx_q == SLOT_W'(TABLE_ENTRIES - 1)) state_q <= S_HB_PICK;
          end
        end

        S_HB_PICK: begin
          priority if (hit_q) begin
            slot_q  <= hit_slot_q;
            act_q   <= ACT_EXISTING;
            work_q  <= hit_e_q;
            state_q <= S_HB_ACC;
          end else if (free_any_q) begin
            slot_q  <= free_slot_q;
            act_q   <= ACT_FREE;
            work_q  <= clear_entry(cur_q.peer_id);
            state_q <= S_HB_ACC;
          end else if (stale_any_q) begin
            slot_q  <= stale_slot_q;
            act_q   <= ACT_EVICT;
            work_q  <= clear_entry(cur_q.peer_id);
            state_q <= S_HB_ACC;
          end else if (newc_strong) begin
            slot_q  <= weak_slot_q;
            act_q   <= ACT_EVICT;
            work_q  <= clear_entry(cur_q.peer_id);
            state_q <= S_HB_ACC;
          end else begin
            state_q <= S_RESP;
          end
        end

        S_HB_ACC: begin
          restart_q       <= !had || rebooted || restarted;
          adv_q           <= cur_q.seq > work_q.last_seq;
          gap_q           <= cur_q.seq - work_q.last_seq - 32'd1;
          work_q.rssi_avg <= (act_q == ACT_EXISTING) ? blend_avg : cur_q.rssi;
          state_q         <= S_HB_UPD;
        end

        S_HB_UPD: begin
          if (restart_q) begin
            work_q.last_seq <= cur_q.seq;
            work_q.rx_cnt   <= 32'd1;
            work_q.gap_cnt  <= '0;
          end else begin
            if (adv_q) begin
              work_q.gap_cnt  <= work_q.gap_cnt + gap_q;
              work_q.win_gap  <= work_q.win_gap + gap_q;
              work_q.last_seq <= cur_q.seq;
            end
            work_q.rx_cnt <= work_q.rx_cnt + 32'd1;
          end
          work_q.win_rx     <= work_q.win_rx + 32'd1;
          work_q.last_heard <= cur_q.now_ms;
          work_q.uptime     <= cur_q.sender_up_ms;
          state_q           <= S_HB_WR;
        end

        S_HB_WR: begin
          used_q[slot_q] <= 1'b1;
          res_acc_q      <= 1'b1;
          state_q        <= S_RESP;
        end

        S_TK_RD: state_q <= S_TK_MUL;

        S_TK_MUL: begin
          if (used_q[cnt_q[SLOT_W-1:0]]) begin
            work_q  <= tk_clr;
            num_q   <= {{(DIV_NUM_W - 32){1'b0}}, mem_q.win_rx} * DIV_NUM_W'(1000);
            den_q   <= {1'b0, mem_q.win_rx} + {1'b0, mem_q.win_gap};
            state_q <= S_TK_START;
          end else if (cnt_q == CNT_W'(TABLE_ENTRIES - 1)) begin
            state_q <= S_OBS_MIN;
          end else begin
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= S_TK_RD;
          end
        end

        S_TK_START: begin
          if (den_q == '0) begin
            work_q.win_pdr <= PDR_NONE;
            state_q        <= S_TK_WR;
          end else begin
            state_q <= S_TK_DIV;
          end
        end

        S_TK_DIV: begin
          if (div_rsp_i.done) begin
            work_q.win_pdr <= div_rsp_i.quo[15:0];
            state_q        <= S_TK_WR;
          end
        end

        S_TK_WR: begin
          if (cnt_q == CNT_W'(TABLE_ENTRIES - 1)) begin
            state_q <= S_OBS_MIN;
          end else begin
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= S_TK_RD;
          end
        end

        S_OBS_MIN: begin
          if (window_q == '0) begin
            share_q <= PERMILLE_FULL;
            state_q <= S_TK_FIN;
          end else begin
            num_q   <= {{(DIV_NUM_W - 32){1'b0}}, obs_min};
            den_q   <= {1'b0, window_q};
            state_q <= S_OBS_MUL;
          end
        end

        S_OBS_MUL: begin
          num_q   <= num_q * DIV_NUM_W'(1000);
          state_q <= S_OBS_START;
        end

        S_OBS_START: begin
          state_q <= S_OBS_DIV;
        end

        S_OBS_DIV: begin
          if (div_rsp_i.done) begin
            share_q <= PERMILLE_FULL - div_rsp_i.quo[9:0];
            state_q <= S_TK_FIN;
          end
        end

        S_TK_FIN: begin
          unobs_q  <= '0;
          wst_q    <= cur_q.now_ms;
          closed_q <= 1'b1;
          state_q  <= S_RESP;
        end

        S_RESP: begin
          if (!rsp_valid_q) begin
            rsp_valid_q                 <= 1'b1;
            rsp_q.accepted              <= res_acc_q;
            rsp_q.slot                  <= res_acc_q ? 5'(slot_q) : 5'd0;
            rsp_q.action                <= res_acc_q ? act_q : ACT_REJECT;
            rsp_q.rssi_avg              <= res_acc_q ? work_q.rssi_avg : 8'sd0;
            rsp_q.gaps_total            <= res_acc_q ? work_q.gap_cnt : 32'd0;
            rsp_q.window_pdr            <= res_acc_q ? work_q.win_pdr : PDR_NONE;
            rsp_q.window_closed         <= closed_q;
            rsp_q.observed_permille     <= share_q;
            state_q                     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PTLQ_ASSERT_IMPL(a_div_start, div_start_q, state_q == S_TK_DIV || state_q == S_OBS_DIV, "bad start")
  `PTLQ_ASSERT_NEXT(a_slot_used, state_q == S_HB_WR, used_q[$past(slot_q)], "entry not marked used")
  `PTLQ_ASSERT_NEXT(a_resp_load, state_q == S_RESP && !rsp_valid_q, rsp_valid_q, "result not loaded")

endmodule

### rtl/peer_table_link_quality_top.sv
// ----------------------------------------------------------------------------
// Peer table link quality estimator, top level
// Front end queue, table engine and shared divider.
// ----------------------------------------------------------------------------
// Every request gets exactly one response. Requests go into a two-deep queue
// and are then worked one at a time by the table engine, which reads its
// table memory (separate read and write ports) one entry per cycle during a
// heartbeat scan. A heartbeat scans all TABLE_ENTRIES entries, then picks a
// slot, accounts the sequence and writes the entry back, or else rejects the
// request. A tick that closes a window walks the table again and runs the
// shared 42-step divider once per used entry with window traffic and, unless
// the window length is zero, once more for the observed share; a tick that
// does not close, a gap request and an unused function code go straight to
// the response. The output register lets the queue keep taking requests while
// a response waits. Register writes are taken at any time but must only be
// issued while no request is in flight.
module peer_table_link_quality_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptlq_req_if.sink    req_i,
  ptlq_rsp_if.source  rsp_o,
  ptlq_cfg_if.sink    cfg_i
);
  import ptlq_pkg::*;

  logic     item_valid;
  logic     item_ready;
  q_item_t  item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // request queue and function decode
  ptlq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // table engine with output register and config registers
  ptlq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .rsp_o        (rsp_o)
  );

  // shared divider for delivery ratios and observed share
  ptlq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer table link quality testbench
// Drives heartbeat, tick, gap and unused-code requests through the request channel and
// register writes, and checks every response against a cycle-free model of the table kept here.
// ----------------------------------------------------------------------------
module tb_top;
  import ptlq_pkg::*;

  localparam int          N_SLOTS   = 32;
  localparam int          POOL_SIZE = 48;     // more ids than slots: forces evictions
  localparam int unsigned MAX_CYCLES = 3_000_000;

  logic clk_i;
  logic rst_ni;

  ptlq_req_if req_bus ();
  ptlq_rsp_if rsp_bus ();
  ptlq_cfg_if cfg_bus ();

  peer_table_link_quality_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // --------------------------------------------------------------------------
  // Table model: registers, per-slot state and window bookkeeping
  // --------------------------------------------------------------------------
  logic [31:0] fresh_lim;
  logic [31:0] win_len;

  logic        slot_used  [N_SLOTS];
  logic [23:0] slot_id    [N_SLOTS];
  logic [31:0] heard_at   [N_SLOTS];
  int          avg_dbm    [N_SLOTS];
  logic [31:0] last_seq   [N_SLOTS];
  logic [31:0] rx_cnt     [N_SLOTS];
  logic [31:0] gap_cnt    [N_SLOTS];
  logic [31:0] win_rx     [N_SLOTS];
  logic [31:0] win_gap    [N_SLOTS];
  logic [15:0] pdr_last   [N_SLOTS];
  logic [31:0] peer_up    [N_SLOTS];
  logic [31:0] win_start;
  logic [31:0] off_accum;
  logic [9:0]  listen_share;

  rsp_t link_results_q[$];   // responses still owed by the block
  int   mismatches;
  int   n_rsp_checked;
  int   n_evicted, n_rejected, n_closed;

  function automatic void wipe_slot(int k, logic [23:0] id);
    slot_used[k] = 1'b1;
    slot_id[k]   = id;
    heard_at[k]  = '0;
    avg_dbm[k]   = 0;
    last_seq[k]  = '0;
    rx_cnt[k]    = '0;
    gap_cnt[k]   = '0;
    win_rx[k]    = '0;
    win_gap[k]   = '0;
    pdr_last[k]  = PDR_NONE;
    peer_up[k]   = '0;
  endfunction

  function automatic void reset_table_model();
    fresh_lim = FRESH_RESET;
    win_len   = WINDOW_RESET;
    for (int k = 0; k < N_SLOTS; k++) begin
      wipe_slot(k, '0);
      slot_used[k] = 1'b0;
    end
    win_start    = '0;
    off_accum    = '0;
    listen_share = PERMILLE_FULL;
  endfunction

  // Find the slot for a heartbeat; act gets the action code, the result is -1 on reject.
  function automatic int find_slot(logic [23:0] id, int dbm, logic [31:0] now,
                                   output logic [1:0] act);
    int          pick;
    logic [31:0] age;
    pick = -1;
    act  = ACT_REJECT;
    for (int k = 0; k < N_SLOTS; k++)
      if (slot_used[k] && slot_id[k] == id) begin
        act = ACT_EXISTING;
        return k;
      end
    for (int k = 0; k < N_SLOTS; k++)
      if (!slot_used[k]) begin
        wipe_slot(k, id);
        act = ACT_FREE;
        return k;
      end
    // full table: stalest entry outside the freshness limit first
    for (int k = 0; k < N_SLOTS; k++) begin
      age = now - heard_at[k];
      if (age < fresh_lim) continue;
      if (pick < 0 || heard_at[k] < heard_at[pick]) pick = k;
    end
    if (pick < 0) begin
      // otherwise the weakest average, only for a clearly stronger newcomer
      pick = 0;
      for (int k = 1; k < N_SLOTS; k++)
        if (avg_dbm[k] < avg_dbm[pick]) pick = k;
      if (dbm <= avg_dbm[pick] + 6) return -1;
    end
    wipe_slot(pick, id);
    act = ACT_EVICT;
    return pick;
  endfunction

  function automatic void count_sequence(int k, logic [31:0] sq, logic [31:0] up);
    logic        had, rebooted, restarted;
    logic [31:0] up_margin, back_step, missed;
    had       = (rx_cnt[k] != 0);
    up_margin = up + 32'd1000;
    back_step = last_seq[k] - sq;
    rebooted  = had && (up_margin < peer_up[k]);
    restarted = had && (sq < last_seq[k]) && (back_step > 32'd100);
    if (!had || rebooted || restarted) begin
      last_seq[k] = sq;
      rx_cnt[k]   = 32'd1;
      gap_cnt[k]  = '0;
      win_rx[k]   = win_rx[k] + 1;
      return;
    end
    if (sq > last_seq[k]) begin
      missed      = sq - last_seq[k] - 32'd1;
      gap_cnt[k]  = gap_cnt[k] + missed;
      win_gap[k]  = win_gap[k] + missed;
      last_seq[k] = sq;
    end
    rx_cnt[k] = rx_cnt[k] + 1;
    win_rx[k] = win_rx[k] + 1;
  endfunction

  function automatic void close_window(logic [31:0] now);
    logic [63:0] tot, part;
    logic [31:0] off;
    for (int k = 0; k < N_SLOTS; k++) begin
      if (!slot_used[k]) continue;
      tot = 64'(win_rx[k]) + 64'(win_gap[k]);
      pdr_last[k] = (tot != 0) ? 16'((64'(win_rx[k]) * 64'd1000) / tot) : PDR_NONE;
      win_rx[k]  = '0;
      win_gap[k] = '0;
    end
    if (win_len == 0) listen_share = PERMILLE_FULL;
    else begin
      off  = (off_accum > win_len) ? win_len : off_accum;
      part = (64'(off) * 64'd1000) / 64'(win_len);
      listen_share = 10'(32'd1000 - 32'(part));
    end
    off_accum = '0;
    win_start = now;
  endfunction

  // Expected response for one request, advancing the model.
  function automatic rsp_t predict_link_quality(req_t r);
    rsp_t        e;
    int          k, dbm;
    logic [1:0]  act;
    logic [31:0] since;
    e            = '0;
    e.window_pdr = PDR_NONE;
    case (r.func)
      FUNC_HEARTBEAT: begin
        dbm = int'(r.rssi);
        k   = find_slot(r.peer_id, dbm, r.now_ms, act);
        if (k >= 0) begin
          count_sequence(k, r.seq, r.sender_up_ms);
          if (act == ACT_EXISTING) avg_dbm[k] = (avg_dbm[k] * 7 + dbm) / 8;
          else                     avg_dbm[k] = dbm;
          heard_at[k]  = r.now_ms;
          peer_up[k]   = r.sender_up_ms;
          e.accepted   = 1'b1;
          e.slot       = 5'(k);
          e.action     = act;
          e.rssi_avg   = 8'(avg_dbm[k]);
          e.gaps_total = gap_cnt[k];
          e.window_pdr = pdr_last[k];
          if (act == ACT_EVICT) n_evicted++;
        end else n_rejected++;
      end
      FUNC_TICK: begin
        since = r.now_ms - win_start;
        if (since >= win_len) begin
          close_window(r.now_ms);
          e.window_closed = 1'b1;
          n_closed++;
        end
      end
      FUNC_GAP: off_accum = off_accum + r.off_ms;
      default: ;
    endcase
    e.observed_permille = listen_share;
    return e;
  endfunction

  function automatic string rsp_text(rsp_t r);
    return $sformatf("acc=%0b slot=%0d act=%0d avg=%0d gaps=%0d pdr=%0d closed=%0b obs=%0d",
                     r.accepted, r.slot, r.action, r.rssi_avg, r.gaps_total,
                     r.window_pdr, r.window_closed, r.observed_permille);
  endfunction

  // --------------------------------------------------------------------------
  // Response side: random stall, compare with the oldest expectation
  // --------------------------------------------------------------------------
  int sink_stall_pct;
  int src_idle_pct;

  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got = rsp_bus.payload;
      if (link_results_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = link_results_q.pop_front();
        n_rsp_checked++;
        if (got.accepted !== want.accepted || got.slot !== want.slot ||
            got.action !== want.action || got.rssi_avg !== want.rssi_avg ||
            got.gaps_total !== want.gaps_total || got.window_pdr !== want.window_pdr ||
            got.window_closed !== want.window_closed ||
            got.observed_permille !== want.observed_permille) begin
          $display("%0t: response mismatch, expected %s", $time, rsp_text(want));
          $display("%0t:                   actual   %s", $time, rsp_text(got));
          mismatches++;
        end
      end
    end
    rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog
  int unsigned cycle_cnt;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("%0t: timeout, %0d responses still owed", $time, link_results_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Tasks are entered right after a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_request(req_t r);
    // sender holds back in a share of cycles given by src_idle_pct
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.payload <= r;
    do @(posedge clk_i); while (!req_bus.ready);
    link_results_q.push_back(predict_link_quality(r));
  endtask

  // Registers only change with nothing in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (link_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.payload.index <= idx;
    cfg_bus.payload.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_FRESH) fresh_lim = val;
    else if (idx == CFG_WINDOW) win_len = val;
    @(posedge clk_i);
  endtask

  function automatic req_t rand_req();
    req_t r;
    r.func         = 2'($urandom_range(3));
    r.now_ms       = $urandom();
    r.peer_id      = 24'($urandom());
    r.seq          = $urandom();
    r.sender_up_ms = $urandom();
    r.rssi         = 8'($urandom());
    r.off_ms       = $urandom();
    return r;
  endfunction

  function automatic req_t heartbeat(logic [31:0] now, logic [23:0] id, logic [31:0] sq,
                                     logic [31:0] up, int dbm);
    req_t r;
    r              = rand_req();
    r.func         = FUNC_HEARTBEAT;
    r.now_ms       = now;
    r.peer_id      = id;
    r.seq          = sq;
    r.sender_up_ms = up;
    r.rssi         = 8'(dbm);
    return r;
  endfunction

  function automatic req_t other_req(logic [1:0] fn, logic [31:0] now, logic [31:0] off);
    req_t r;
    r        = rand_req();
    r.func   = fn;
    r.now_ms = now;
    r.off_ms = off;
    return r;
  endfunction

  // Well-formed traffic state for the random part
  logic [23:0] pool_id  [POOL_SIZE];
  logic [31:0] pool_seq [POOL_SIZE];
  logic [31:0] pool_up  [POOL_SIZE];
  logic [31:0] clock_ms;

  // Extremes of the fields, each function code, restart and reboot paths.
  task automatic test_directed();
    send_request(heartbeat(32'd100, 24'h000000, 32'd0, 32'd5000, -128));
    send_request(heartbeat(32'd200, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 127));
    send_request(heartbeat(32'd300, 24'h000000, 32'd5, 32'd6000, 127));  // four missed
    send_request(heartbeat(32'd400, 24'h000000, 32'd3, 32'd7000, -1));   // late, no gap
    send_request(heartbeat(32'd500, 24'h000000, 32'd200, 32'd8000, 0));
    send_request(heartbeat(32'd600, 24'h000000, 32'd50, 32'd9000, -60)); // seq restart
    send_request(heartbeat(32'd700, 24'h000000, 32'd60, 32'd10, -60));   // sender reboot
    send_request(heartbeat(32'd800, 24'hFFFFFF, 32'd0, 32'd1, -128));    // reboot, low seq
    send_request(other_req(FUNC_GAP, 32'd900, 32'hFFFF_FFFF));
    send_request(other_req(FUNC_GAP, 32'd950, 32'd3000));
    send_request(other_req(FUNC_TICK, 32'd5000, 32'd0));     // window still open
    send_request(other_req(2'd3, 32'd6000, 32'hFFFF_FFFF));  // unused code
    send_request(other_req(FUNC_TICK, 32'd20000, 32'd0));    // closes, gap total wrapped below the window
    send_request(other_req(FUNC_GAP, 32'd21000, 32'd4000));
    send_request(heartbeat(32'd22000, 24'h000000, 32'd61, 32'd2000, 100));
    send_request(other_req(FUNC_TICK, 32'd30000, 32'd0));    // exactly one window
    send_request(heartbeat(32'd31000, 24'hFFFFFF, 32'd1, 32'd2000, 50));
    send_request(other_req(FUNC_TICK, 32'd30500, 32'd0));    // time going back, window still open
  endtask

  // Fill the table, then try newcomers against the RSSI rule.
  task automatic test_full_table();
    write_reg(CFG_FRESH, 32'hFFFF_FFFF);
    for (int i = 0; i < N_SLOTS; i++)
      send_request(heartbeat(32'd40000 + i, pool_id[i], 32'd1, 32'd100, -60 + (i % 3)));
    send_request(heartbeat(32'd41000, pool_id[40], 32'd1, 32'd100, -54)); // exactly 6 dB
    send_request(heartbeat(32'd41001, pool_id[41], 32'd1, 32'd100, -53)); // evicts weakest
    write_reg(CFG_FRESH, 32'd0);                                          // all stale
    send_request(heartbeat(32'd41002, pool_id[42], 32'd1, 32'd100, -128));
    clock_ms = 32'd42000;
  endtask

  // Mostly well-formed per-peer streams with random content, some noise.
  task automatic test_random_traffic(int n_items);
    int   p, roll;
    req_t r;
    for (int i = 0; i < n_items; i++) begin
      roll     = $urandom_range(99);
      clock_ms = clock_ms + (($urandom_range(19) == 0) ? $urandom() : $urandom_range(3000));
      if (roll < 72) begin
        p = $urandom_range(POOL_SIZE - 1);
        case ($urandom_range(19))
          0:       pool_seq[p] = $urandom();                  // restart or jump
          1:       pool_up[p]  = $urandom_range(500);         // reboot
          2:       pool_seq[p] = pool_seq[p] - $urandom_range(120);
          default: pool_seq[p] = pool_seq[p] + $urandom_range(1, 3);
        endcase
        pool_up[p] = pool_up[p] + $urandom_range(3000);
        send_request(heartbeat(clock_ms, pool_id[p], pool_seq[p], pool_up[p],
                               $signed($urandom_range(255)) - 128));
      end else if (roll < 84) send_request(other_req(FUNC_TICK, clock_ms, 32'd0));
      else if (roll < 94) send_request(other_req(FUNC_GAP, clock_ms,
                                       ($urandom_range(9) == 0) ? $urandom()
                                                                : $urandom_range(5000)));
      else begin
        r = rand_req();
        send_request(r);
      end
    end
  endtask

  initial begin
    req_t idle_req;
    idle_req          = '0;
    rst_ni            = 1'b0;
    cycle_cnt         = 0;
    mismatches        = 0;
    n_rsp_checked     = 0;
    n_evicted         = 0;
    n_rejected        = 0;
    n_closed          = 0;
    src_idle_pct      = 12;
    sink_stall_pct    = 78;
    req_bus.valid     <= 1'b0;
    req_bus.payload   <= idle_req;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.payload   <= '0;
    reset_table_model();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_id[i]  = 24'($urandom());
      pool_seq[i] = $urandom_range(1000);
      pool_up[i]  = $urandom_range(100000);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    write_reg(CFG_FRESH, 32'd60000);
    write_reg(CFG_WINDOW, 32'd1);              // nearly every tick closes
    test_random_traffic(120);

    src_idle_pct   = 78;
    sink_stall_pct = 12;
    write_reg(CFG_FRESH, 32'd5000);
    write_reg(CFG_WINDOW, 32'd0);              // zero length: always closes, full share
    test_random_traffic(60);
    write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
    write_reg(CFG_FRESH, 32'hFFFF_FFFF);
    test_random_traffic(60);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_reg(CFG_FRESH, 32'd0);
    write_reg(CFG_WINDOW, 32'd8000);
    test_random_traffic(80);
    write_reg(CFG_FRESH, $urandom());
    write_reg(CFG_WINDOW, $urandom_range(20000, 1));
    test_random_traffic(80);

    req_bus.valid <= 1'b0;
    while (link_results_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Checked %0d responses: %0d evictions, %0d rejects, %0d windows closed,",
             n_rsp_checked, n_evicted, n_rejected, n_closed);
    $display("over several freshness and window settings and three handshake pacings.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ptlq_pkg.sv
rtl/ptlq_if.sv
rtl/ptlq_div.sv
rtl/ptlq_front.sv
rtl/ptlq_back.sv
rtl/peer_table_link_quality_top.sv
tb/sv/tb_top.sv
